@@ rtl/assert_macros.svh @@
// Assertion macros for the lighting mode controller.
// The including module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge while out of reset.
`define LMC_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LMC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lmc_pkg.sv @@
// Shared types and constants for the lighting mode controller.
// Used by lmc_core and lighting_mode_controller; no dependencies.
package lmc_pkg;

	localparam int unsigned LightW = 10;
	localparam int unsigned LimitW = 8;
	localparam int unsigned ModeW = 2;

	localparam logic [LightW-1:0] LightThresholdRst = LightW'(400);
	localparam logic [LimitW-1:0] IrEdgeLimitRst = LimitW'(15);

	localparam int unsigned InDataW = 16;
	localparam int unsigned OutDataW = 8;
	localparam int unsigned AddrW = 3;

	// Register indexes on the configuration port (word address).
	typedef enum logic {
		REG_LIGHT_THRESHOLD = 1'b0,
		REG_IR_EDGE_LIMIT = 1'b1
	} reg_idx_t;

	// Infrared mode cycle positions.
	localparam logic [ModeW-1:0] ModeNextOn = 2'd0;
	localparam logic [ModeW-1:0] ModeNextOff = 2'd1;
	localparam logic [ModeW-1:0] ModeNextAuto = 2'd2;

	typedef struct packed {
		logic [LightW-1:0] light_threshold;
		logic [LimitW-1:0] ir_edge_limit;
	} cfg_t;

	typedef struct packed {
		logic mains_sensed;
		logic off_pressed;
		logic on_pressed;
		logic manual_pressed;
		logic ir_line_high;
		logic motion_high;
		logic [LightW-1:0] light_level;
	} poll_t;

	typedef struct packed {
		logic [ModeW-1:0] remote_mode;
		logic mains_indicator;
		logic manual_active;
		logic lamp_on;
	} result_t;

endpackage

@@ rtl/lmc_core.sv @@
// Lamp control state and its next-state logic for one sensor poll.
// Depends on lmc_pkg.
module lmc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  lmc_pkg::cfg_t  cfg,
	input  lmc_pkg::poll_t poll,
	output lmc_pkg::result_t result
);

	logic                        ir_prev_high_q;
	logic [lmc_pkg::LimitW-1:0]  ir_edge_count_q;
	logic [lmc_pkg::ModeW-1:0]   ir_mode_q;
	logic                        motion_prev_q;
	logic                        manual_mode_q;
	logic                        manual_released_q;
	logic                        on_released_q;
	logic                        off_released_q;
	logic                        lamp_state_q;

	logic [lmc_pkg::LimitW:0]    count_inc;
	logic                        ir_fall;
	logic                        ir_fire;
	logic [lmc_pkg::LimitW-1:0]  count_d;
	logic [lmc_pkg::ModeW-1:0]   mode_d;
	logic                        man_a, lamp_a;
	logic                        man_b, lamp_b;
	logic                        man_d, lamp_d;
	logic                        on_rel_d, off_rel_d;

	always_comb begin
		count_inc = {1'b0, ir_edge_count_q} + 1'b1;
		ir_fall = !poll.ir_line_high && ir_prev_high_q;
		ir_fire = ir_fall && (count_inc > {1'b0, cfg.ir_edge_limit});

		// Infrared mode cycle.
		count_d = ir_edge_count_q;
		mode_d = ir_mode_q;
		man_a = manual_mode_q;
		lamp_a = lamp_state_q;
		if (ir_fire) begin
			count_d = '0;
			case (ir_mode_q)
				lmc_pkg::ModeNextOn: begin
					man_a = 1'b1;
					lamp_a = 1'b1;
					mode_d = lmc_pkg::ModeNextOff;
				end
				lmc_pkg::ModeNextOff: begin
					man_a = 1'b1;
					lamp_a = 1'b0;
					mode_d = lmc_pkg::ModeNextAuto;
				end
				default: begin
					man_a = 1'b0;
					mode_d = lmc_pkg::ModeNextOn;
				end
			endcase
		end else if (ir_fall) begin
			count_d = count_inc[lmc_pkg::LimitW-1:0];
		end

		// Motion edges.
		man_b = man_a;
		lamp_b = lamp_a;
		if (poll.motion_high && !motion_prev_q) begin
			if (poll.light_level > cfg.light_threshold && !man_a) begin
				man_b = 1'b1;
				lamp_b = 1'b1;
			end
		end else if (!poll.motion_high && motion_prev_q && man_a) begin
			man_b = 1'b0;
			lamp_b = 1'b0;
		end

		// Manual button toggles on its press edge.
		man_d = man_b ^ (poll.manual_pressed && manual_released_q);

		lamp_d = lamp_b;
		on_rel_d = on_released_q;
		off_rel_d = off_released_q;
		if (!man_d) begin
			lamp_d = !poll.mains_sensed;
		end else begin
			if (poll.on_pressed && on_released_q) begin
				lamp_d = 1'b1;
			end
			on_rel_d = !poll.on_pressed;
			// The off edge applies after the on edge, so off wins a tie.
			if (poll.off_pressed && off_released_q) begin
				lamp_d = 1'b0;
			end
			off_rel_d = !poll.off_pressed;
		end

		result.lamp_on = lamp_d;
		result.manual_active = man_d;
		result.mains_indicator = poll.mains_sensed;
		result.remote_mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_prev_high_q <= 1'b0;
			ir_edge_count_q <= '0;
			ir_mode_q <= lmc_pkg::ModeNextOn;
			motion_prev_q <= 1'b0;
			manual_mode_q <= 1'b0;
			manual_released_q <= 1'b1;
			on_released_q <= 1'b1;
			off_released_q <= 1'b1;
			lamp_state_q <= 1'b0;
		end else if (step) begin
			ir_prev_high_q <= poll.ir_line_high;
			ir_edge_count_q <= count_d;
			ir_mode_q <= mode_d;
			motion_prev_q <= poll.motion_high;
			manual_mode_q <= man_d;
			manual_released_q <= !poll.manual_pressed;
			on_released_q <= on_rel_d;
			off_released_q <= off_rel_d;
			lamp_state_q <= lamp_d;
		end
	end

endmodule

@@ rtl/lighting_mode_controller.sv @@
// Top level of the lighting mode controller: stream ports, input stage,
// result register, configuration registers and assertions.
// Depends on lmc_pkg, lmc_core and assert_macros.svh.
//
//   Channel   Group                       Direction  Payload
//   poll      s_tvalid/s_tready/s_tdata   in         16-bit sensor poll
//   result    m_tvalid/m_tready/m_tdata   out        8-bit lamp status
//   config    psel/penable/pwrite/...     in/out     two registers on 32-bit bus
//
// A poll is registered, evaluated combinationally against the state and lands
// in the result register, one transaction per cycle while results are taken.
// The input stage and the result register each hold one item, so a stalled
// consumer lets two polls in before s_tready drops. Reset clears all
// control state and loads the register defaults; no clearing pass follows.
module lighting_mode_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [9:0] light_level, [10] motion_high, [11] ir_line_high,
	// [12] manual_pressed, [13] on_pressed, [14] off_pressed, [15] mains_sensed
	input  logic [lmc_pkg::InDataW-1:0]   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] lamp_on, [1] manual_active, [2] mains_indicator, [4:3] remote_mode,
	// [7:5] zero
	output logic [lmc_pkg::OutDataW-1:0]  m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lmc_pkg::AddrW-1:0]     paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	lmc_pkg::cfg_t     cfg_q;
	lmc_pkg::poll_t    poll_s1;
	logic              valid_s1;
	lmc_pkg::result_t  result;
	lmc_pkg::result_t  result_q;
	logic              out_valid_q;
	logic              advance;
	logic              step;
	lmc_pkg::reg_idx_t reg_sel;

	assign pready = 1'b1;
	assign reg_sel = lmc_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_threshold <= lmc_pkg::LightThresholdRst;
			cfg_q.ir_edge_limit <= lmc_pkg::IrEdgeLimitRst;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				lmc_pkg::REG_LIGHT_THRESHOLD:
					cfg_q.light_threshold <= pwdata[lmc_pkg::LightW-1:0];
				lmc_pkg::REG_IR_EDGE_LIMIT:
					cfg_q.ir_edge_limit <= pwdata[lmc_pkg::LimitW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			lmc_pkg::REG_LIGHT_THRESHOLD:
				prdata = 32'(cfg_q.light_threshold);
			lmc_pkg::REG_IR_EDGE_LIMIT:
				prdata = 32'(cfg_q.ir_edge_limit);
			default: prdata = '0;
		endcase
	end

	// The input stage moves on whenever the result register is free or drains.
	assign advance = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			poll_s1 <= lmc_pkg::poll_t'(s_tdata);
		end
		if (step) begin
			result_q <= result;
		end
	end

	lmc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.poll   (poll_s1),
		.result (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = lmc_pkg::OutDataW'(result_q);

`include "assert_macros.svh"

	`LMC_ASSERT_IMPLY(a_mode_range, m_tvalid, m_tdata[4:3] != 2'd3, "remote_mode out of range")
	`LMC_ASSERT_IMPLY(a_auto_lamp, m_tvalid && !m_tdata[1], m_tdata[0] == !m_tdata[2], "auto lamp mismatch")
	`LMC_ASSERT_IMPLY(a_ready_empty, !m_tvalid, s_tready, "input stalled with empty output")
	`LMC_ASSERT_NEXT(a_step_fills, step, m_tvalid, "evaluated poll did not reach output")

endmodule
